[design/bdq_pkg.sv]
package bdq_pkg;

    localparam int DATA_W = 32;

    typedef enum logic [2:0] {
        REQ_PUSH_FRONT = 3'd0,
        REQ_PUSH_BACK  = 3'd1,
        REQ_POP_FRONT  = 3'd2,
        REQ_POP_BACK   = 3'd3,
        REQ_SEARCH     = 3'd4
    } req_t;

    typedef enum logic [1:0] {
        STS_OK       = 2'd0,
        STS_FULL     = 2'd1,
        STS_EMPTY    = 2'd2,
        STS_NOTFOUND = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_POP_WAIT,
        ST_SCAN,
        ST_FINISH
    } state_t;

endpackage

[design/bounded_deque_with_search.sv]
// Channel   Direction  Handshake             Payload
// request   in         req_valid/req_stall   req_type, value
// response  out        rsp_valid/rsp_stall   status, popped_value, position, occupancy
//
// Push: IDLE, EXEC, FINISH, then the output register. Pop: EXEC, POP_WAIT, FINISH.
// Search: SCAN ends at a hit at position N; a miss reads every entry, at most DEPTH.
// The single read port of the entry RAM sets the scan rate: one entry per cycle.
// Reset clears count and front slot; RAM contents stay undefined until written.
// A stalled response holds the output register; a new request is taken once idle.
module bounded_deque_with_search
    import bdq_pkg::*;
    #(
        parameter int DEPTH = 16
    )
    (
        input  logic                             clk,
        input  logic                             rst_n,
        input  logic                             req_valid,
        output logic                             req_stall,
        input  logic [2:0]                       req_type,
        input  logic signed [DATA_W-1:0]         value,
        output logic                             rsp_valid,
        input  logic                             rsp_stall,
        output logic [1:0]                       status,
        output logic signed [DATA_W-1:0]         popped_value,
        output logic [$clog2(DEPTH+1)-1:0]       position,
        output logic [$clog2(DEPTH+1)-1:0]       occupancy
    );

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = IDX_W + 1;
    localparam logic [SUM_W-1:0] DEPTH_S   = SUM_W'(DEPTH);
    localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] DEPTH_C   = CNT_W'(DEPTH);

    function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] base,
                                                 input logic [CNT_W-1:0] off);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(base) + SUM_W'(off);
        if (sum >= DEPTH_S)
        begin
            sum = sum - DEPTH_S;
        end
        return sum[IDX_W-1:0];
    endfunction

    function automatic logic [IDX_W-1:0] slot_inc(input logic [IDX_W-1:0] s);
        return (s == LAST_SLOT) ? '0 : s + IDX_W'(1);
    endfunction

    function automatic logic [IDX_W-1:0] slot_dec(input logic [IDX_W-1:0] s);
        return (s == '0) ? LAST_SLOT : s - IDX_W'(1);
    endfunction

    state_t                  state_reg, state_next;
    req_t                    req_reg, req_next;
    logic [DATA_W-1:0]       value_reg, value_next;
    logic [IDX_W-1:0]        front_reg, front_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [IDX_W-1:0]        rd_slot_reg, rd_slot_next;
    logic [CNT_W-1:0]        scan_idx_reg, scan_idx_next;
    status_t                 res_status_reg, res_status_next;
    logic [CNT_W-1:0]        res_pos_reg, res_pos_next;
    logic                    res_pop_reg, res_pop_next;
    logic                    rsp_valid_reg, rsp_valid_next;
    status_t                 status_reg, status_next;
    logic [DATA_W-1:0]       popped_reg, popped_next;
    logic [CNT_W-1:0]        position_reg, position_next;
    logic [CNT_W-1:0]        occupancy_reg, occupancy_next;
    logic [DATA_W-1:0]       popped_hold_reg, popped_hold_next;

    logic                    wr_en;
    logic [IDX_W-1:0]        wr_addr;
    logic [IDX_W-1:0]        rd_addr;
    logic [DATA_W-1:0]       rd_data;
    logic                    req_fire;
    logic                    out_free;
    logic                    hit;
    logic                    scan_last;

    bdq_ram
        #(
            .WIDTH (DATA_W),
            .DEPTH (DEPTH)
        )
        u_ram
        (
            .clk     (clk),
            .wr_en   (wr_en),
            .wr_addr (wr_addr),
            .wr_data (value_reg),
            .rd_addr (rd_addr),
            .rd_data (rd_data)
        );

    assign req_stall = (state_reg != ST_IDLE);
    assign req_fire  = req_valid && !req_stall;
    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign hit       = (rd_data == value_reg);
    assign scan_last = ((scan_idx_reg + CNT_W'(1)) == count_reg);

    assign rsp_valid    = rsp_valid_reg;
    assign status       = status_reg;
    assign popped_value = $signed(popped_reg);
    assign position     = position_reg;
    assign occupancy    = occupancy_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (((req_reg == REQ_POP_FRONT) || (req_reg == REQ_POP_BACK))
                    && (count_reg != '0))
                begin
                    state_next = ST_POP_WAIT;
                end
                else if ((req_reg == REQ_SEARCH) && (count_reg != '0))
                begin
                    state_next = ST_SCAN;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_POP_WAIT:
            begin
                state_next = ST_FINISH;
            end
            ST_SCAN:
            begin
                if (hit || scan_last)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req_next         = req_reg;
        value_next       = value_reg;
        front_next       = front_reg;
        count_next       = count_reg;
        rd_slot_next     = rd_slot_reg;
        scan_idx_next    = scan_idx_reg;
        res_status_next  = res_status_reg;
        res_pos_next     = res_pos_reg;
        res_pop_next     = res_pop_reg;
        popped_hold_next = popped_hold_reg;
        rsp_valid_next   = rsp_valid_reg;
        status_next      = status_reg;
        popped_next      = popped_reg;
        position_next    = position_reg;
        occupancy_next   = occupancy_reg;
        wr_en            = 1'b0;
        wr_addr          = front_reg;
        rd_addr          = rd_slot_reg;

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    req_next   = req_t'(req_type);
                    value_next = value;
                end
            end
            ST_EXEC:
            begin
                res_status_next = STS_OK;
                res_pos_next    = '0;
                res_pop_next    = 1'b0;
                case (req_reg)
                    REQ_PUSH_FRONT:
                    begin
                        if (count_reg == DEPTH_C)
                        begin
                            res_status_next = STS_FULL;
                        end
                        else
                        begin
                            wr_en      = 1'b1;
                            wr_addr    = slot_dec(front_reg);
                            front_next = slot_dec(front_reg);
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                    REQ_PUSH_BACK:
                    begin
                        if (count_reg == DEPTH_C)
                        begin
                            res_status_next = STS_FULL;
                        end
                        else
                        begin
                            wr_en      = 1'b1;
                            wr_addr    = slot_of(front_reg, count_reg);
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                    REQ_POP_FRONT:
                    begin
                        if (count_reg == '0)
                        begin
                            res_status_next = STS_EMPTY;
                        end
                        else
                        begin
                            rd_addr      = front_reg;
                            res_pop_next = 1'b1;
                            front_next   = slot_inc(front_reg);
                            count_next   = count_reg - CNT_W'(1);
                        end
                    end
                    REQ_POP_BACK:
                    begin
                        if (count_reg == '0)
                        begin
                            res_status_next = STS_EMPTY;
                        end
                        else
                        begin
                            rd_addr      = slot_of(front_reg, count_reg - CNT_W'(1));
                            res_pop_next = 1'b1;
                            count_next   = count_reg - CNT_W'(1);
                        end
                    end
                    REQ_SEARCH:
                    begin
                        if (count_reg == '0)
                        begin
                            res_status_next = STS_EMPTY;
                        end
                        else
                        begin
                            rd_addr       = front_reg;
                            rd_slot_next  = front_reg;
                            scan_idx_next = '0;
                        end
                    end
                    default:
                    begin
                        res_status_next = STS_OK;
                    end
                endcase
            end
            ST_POP_WAIT:
            begin
                popped_hold_next = rd_data;
            end
            ST_SCAN:
            begin
                if (hit)
                begin
                    res_status_next = STS_OK;
                    res_pos_next    = scan_idx_reg + CNT_W'(1);
                end
                else if (scan_last)
                begin
                    res_status_next = STS_NOTFOUND;
                end
                else
                begin
                    rd_addr       = slot_inc(rd_slot_reg);
                    rd_slot_next  = slot_inc(rd_slot_reg);
                    scan_idx_next = scan_idx_reg + CNT_W'(1);
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    rsp_valid_next = 1'b1;
                    status_next    = res_status_reg;
                    popped_next    = res_pop_reg ? popped_hold_reg : '0;
                    position_next  = res_pos_reg;
                    occupancy_next = count_reg;
                end
            end
            default:
            begin
                rd_addr = rd_slot_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            front_reg     <= '0;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            front_reg     <= front_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg         <= req_next;
        value_reg       <= value_next;
        rd_slot_reg     <= rd_slot_next;
        scan_idx_reg    <= scan_idx_next;
        res_status_reg  <= res_status_next;
        res_pos_reg     <= res_pos_next;
        res_pop_reg     <= res_pop_next;
        popped_hold_reg <= popped_hold_next;
        status_reg      <= status_next;
        popped_reg      <= popped_next;
        position_reg    <= position_next;
        occupancy_reg   <= occupancy_next;
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_C)
        else $error("entry count above depth");

    a_full_occ: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (status == STS_FULL)) |-> (occupancy == DEPTH_C))
        else $error("overflow reported while not full");

    a_empty_occ: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (status == STS_EMPTY)) |-> (occupancy == '0))
        else $error("underflow reported while not empty");

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (position != '0)) |-> ((status == STS_OK) && (position <= occupancy)))
        else $error("search position out of range");
`endif

endmodule

[design/bdq_ram.sv]
module bdq_ram
    #(
        parameter int WIDTH = 32,
        parameter int DEPTH = 16
    )
    (
        input  logic                     clk,
        input  logic                     wr_en,
        input  logic [$clog2(DEPTH)-1:0] wr_addr,
        input  logic [WIDTH-1:0]         wr_data,
        input  logic [$clog2(DEPTH)-1:0] rd_addr,
        output logic [WIDTH-1:0]         rd_data
    );

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

[tb/bounded_deque_with_search_tb.sv]
module bounded_deque_with_search_tb;
    import bdq_pkg::*;

    localparam int DEPTH = 16;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int QUIET_LIMIT = 2000;
    localparam int ITEMS_PER_PHASE = 350;
    localparam int DIR_ROWS = 15;
    localparam logic [2:0] REQ_RSVD_FIRST = 3'd5;
    localparam logic [2:0] REQ_RSVD_LAST = 3'd7;

    typedef struct packed {
        status_t           sts;
        logic [DATA_W-1:0] pop;
        logic [CNT_W-1:0]  pos;
        logic [CNT_W-1:0]  occ;
    } deque_reply_t;

    typedef struct packed {
        logic [2:0]        op;
        logic [DATA_W-1:0] val;
        logic [4:0]        reps;
        logic              typed;
        deque_reply_t      want;
    } dir_row_t;

    localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
        '{REQ_POP_FRONT,  32'h0,        5'd1,  1'b1, '{STS_EMPTY,    32'h0,        5'd0,  5'd0}},
        '{REQ_POP_BACK,   32'h0,        5'd1,  1'b1, '{STS_EMPTY,    32'h0,        5'd0,  5'd0}},
        '{REQ_SEARCH,     32'h0,        5'd1,  1'b1, '{STS_EMPTY,    32'h0,        5'd0,  5'd0}},
        '{REQ_RSVD_LAST,  32'h0,        5'd1,  1'b1, '{STS_OK,       32'h0,        5'd0,  5'd0}},
        '{REQ_PUSH_BACK,  32'h7FFFFFFF, 5'd1,  1'b1, '{STS_OK,       32'h0,        5'd0,  5'd1}},
        '{REQ_PUSH_FRONT, 32'h80000000, 5'd1,  1'b1, '{STS_OK,       32'h0,        5'd0,  5'd2}},
        '{REQ_SEARCH,     32'h0,        5'd1,  1'b1, '{STS_NOTFOUND, 32'h0,        5'd0,  5'd2}},
        '{REQ_POP_BACK,   32'h0,        5'd1,  1'b1, '{STS_OK,       32'h7FFFFFFF, 5'd0,  5'd1}},
        '{REQ_PUSH_BACK,  32'h1,        5'd14, 1'b0, '{STS_OK,       32'h0,        5'd0,  5'd0}},
        '{REQ_PUSH_BACK,  32'hFFFFFFFF, 5'd1,  1'b1, '{STS_OK,       32'h0,        5'd0,  5'd16}},
        '{REQ_PUSH_FRONT, 32'h0,        5'd1,  1'b1, '{STS_FULL,     32'h0,        5'd0,  5'd16}},
        '{REQ_PUSH_BACK,  32'h0,        5'd1,  1'b1, '{STS_FULL,     32'h0,        5'd0,  5'd16}},
        '{REQ_SEARCH,     32'hFFFFFFFF, 5'd1,  1'b1, '{STS_OK,       32'h0,        5'd16, 5'd16}},
        '{REQ_SEARCH,     32'h80000000, 5'd1,  1'b1, '{STS_OK,       32'h0,        5'd1,  5'd16}},
        '{REQ_POP_FRONT,  32'h0,        5'd1,  1'b1, '{STS_OK,       32'h80000000, 5'd0,  5'd15}}
    };

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     req_valid = 1'b0;
    logic                     req_stall;
    logic [2:0]               req_type = 3'd0;
    logic signed [DATA_W-1:0] value = '0;
    logic                     rsp_valid;
    logic                     rsp_stall = 1'b0;
    logic [1:0]               status;
    logic signed [DATA_W-1:0] popped_value;
    logic [CNT_W-1:0]         position;
    logic [CNT_W-1:0]         occupancy;

    logic [DATA_W-1:0] mirror_slots [DEPTH];
    int                mirror_front = 0;
    int                mirror_count = 0;
    deque_reply_t      owed_replies [$];
    deque_reply_t      oldest;

    int gap_pct = 0;
    int stall_pct = 0;
    int quiet_cycles = 0;
    int mismatches = 0;
    int requests_sent = 0;
    int replies_seen = 0;
    int peak_occupancy = 0;
    int status_hits [4] = '{0, 0, 0, 0};

    bounded_deque_with_search #(
        .DEPTH(DEPTH)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .req_type    (req_type),
        .value       (value),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .status      (status),
        .popped_value(popped_value),
        .position    (position),
        .occupancy   (occupancy)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic deque_reply_t apply_to_mirror(logic [2:0] op, logic [DATA_W-1:0] val);
        deque_reply_t r;
        int           i;
        r = '{STS_OK, '0, '0, '0};
        case (op)
            REQ_PUSH_FRONT, REQ_PUSH_BACK:
            begin
                if (mirror_count == DEPTH)
                    r.sts = STS_FULL;
                else if (op == REQ_PUSH_FRONT)
                begin
                    mirror_front = (mirror_front + DEPTH - 1) % DEPTH;
                    mirror_slots[mirror_front] = val;
                    mirror_count++;
                end
                else
                begin
                    mirror_slots[(mirror_front + mirror_count) % DEPTH] = val;
                    mirror_count++;
                end
            end
            REQ_POP_FRONT, REQ_POP_BACK:
            begin
                if (mirror_count == 0)
                    r.sts = STS_EMPTY;
                else if (op == REQ_POP_FRONT)
                begin
                    r.pop = mirror_slots[mirror_front];
                    mirror_front = (mirror_front + 1) % DEPTH;
                    mirror_count--;
                end
                else
                begin
                    r.pop = mirror_slots[(mirror_front + mirror_count - 1) % DEPTH];
                    mirror_count--;
                end
            end
            REQ_SEARCH:
            begin
                if (mirror_count == 0)
                    r.sts = STS_EMPTY;
                else
                begin
                    r.sts = STS_NOTFOUND;
                    for (i = 0; i < mirror_count; i++)
                    begin
                        if (r.sts != STS_OK && mirror_slots[(mirror_front + i) % DEPTH] == val)
                        begin
                            r.sts = STS_OK;
                            r.pos = CNT_W'(i + 1);
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
        r.occ = CNT_W'(mirror_count);
        return r;
    endfunction

    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(9))
            0: return 32'h7FFFFFFF;
            1: return 32'h80000000;
            2: return 32'h0;
            3: return 32'hFFFFFFFF;
            4, 5: return DATA_W'($urandom_range(7));
            default: return $urandom;
        endcase
    endfunction

    task automatic flag_mismatch(string what, longint got, longint want);
        $display("mismatch in %s at result %0d: got %0d, expected %0d",
                 what, replies_seen, got, want);
        mismatches++;
    endtask

    task automatic issue(logic [2:0] op, logic [DATA_W-1:0] val, logic typed,
                         deque_reply_t want);
        deque_reply_t pred;
        while ($urandom_range(99) < gap_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req_type  <= op;
        value     <= val;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        pred = apply_to_mirror(op, val);
        owed_replies.push_back(typed ? want : pred);
        requests_sent++;
    endtask

    task automatic drain_replies();
        req_valid <= 1'b0;
        while (owed_replies.size() != 0)
            @(posedge clk);
    endtask

    always @(posedge clk)
        rsp_stall <= ($urandom_range(99) < stall_pct);

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (owed_replies.size() == 0)
                flag_mismatch("transaction with nothing owed", status, 0);
            else
            begin
                oldest = owed_replies.pop_front();
                if (status != oldest.sts)
                    flag_mismatch("status", status, oldest.sts);
                if (popped_value != $signed(oldest.pop))
                    flag_mismatch("popped_value", popped_value, $signed(oldest.pop));
                if (position != oldest.pos)
                    flag_mismatch("position", position, oldest.pos);
                if (occupancy != oldest.occ)
                    flag_mismatch("occupancy", occupancy, oldest.occ);
            end
            status_hits[status]++;
            replies_seen++;
            if (occupancy > peak_occupancy)
                peak_occupancy = occupancy;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
                quiet_cycles <= 0;
            else if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("watchdog: no transaction for %0d cycles", QUIET_LIMIT);
                $display("** bounded_deque_with_search: FAILED **");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        int           r;
        int           k;
        int           phase;
        int           n;
        bit           filling;
        logic [2:0]   op;
        logic [31:0]  val;
        deque_reply_t none;
        int           phase_gap [4];
        int           phase_stall [4];

        phase_gap   = '{0, 52, 0, 12};
        phase_stall = '{0, 0, 52, 12};
        none = '{STS_OK, '0, '0, '0};
        filling = 1'b0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (r = 0; r < DIR_ROWS; r++)
            for (k = 0; k < DIR_TABLE[r].reps; k++)
                issue(DIR_TABLE[r].op, DIR_TABLE[r].val, DIR_TABLE[r].typed, DIR_TABLE[r].want);
        drain_replies();

        for (phase = 0; phase < 4; phase++)
        begin
            gap_pct   = phase_gap[phase];
            stall_pct = phase_stall[phase];
            for (n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if (mirror_count == DEPTH)
                    filling = 1'b0;
                else if (mirror_count == 0)
                    filling = 1'b1;
                else if ($urandom_range(31) == 0)
                    filling = !filling;
                r = $urandom_range(99);
                if (r < 2)
                    op = 3'($urandom_range(REQ_RSVD_FIRST, REQ_RSVD_LAST));
                else if (r < 22)
                    op = REQ_SEARCH;
                else if (r < (filling ? 80 : 45))
                    op = $urandom_range(1) ? REQ_PUSH_FRONT : REQ_PUSH_BACK;
                else
                    op = $urandom_range(1) ? REQ_POP_FRONT : REQ_POP_BACK;
                if (op == REQ_SEARCH && mirror_count > 0 && $urandom_range(9) < 7)
                    val = mirror_slots[(mirror_front + $urandom_range(mirror_count - 1)) % DEPTH];
                else
                    val = pick_value();
                issue(op, val, 1'b0, none);
            end
            // hold the sender until every owed transaction is back
            drain_replies();
        end

        stall_pct = 0;
        repeat (DEPTH + 8) @(posedge clk);

        $display("%0d requests over four handshake phases, %0d results checked, %0d mismatches",
                 requests_sent, replies_seen, mismatches);
        $display("results: ok %0d, full %0d, empty %0d, not found %0d; peak occupancy %0d",
                 status_hits[STS_OK], status_hits[STS_FULL], status_hits[STS_EMPTY],
                 status_hits[STS_NOTFOUND], peak_occupancy);
        if (mismatches == 0 && owed_replies.size() == 0)
            $display("** bounded_deque_with_search: PASSED **");
        else
            $display("** bounded_deque_with_search: FAILED **");
        $finish;
    end

endmodule

[files.f]
design/bdq_pkg.sv
design/bdq_ram.sv
design/bounded_deque_with_search.sv
tb/bounded_deque_with_search_tb.sv
